// ===== hw/rtl/fqsm_pkg.sv =====
// Shared types, widths and codes for the FIFO with running sum and mean.
package fqsm_pkg;

  localparam int DEPTH_DEF    = 128;
  localparam int ACTION_W     = 2;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int HELD_COUNT_W = 8;
  localparam int SUM_W        = 39;
  localparam int MEAN_W       = 32;
  localparam int CMDQ_DEPTH   = 2;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam logic [ACTION_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQ = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLR = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_CLR,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  function automatic logic signed [SUM_W-1:0] sext_value(input logic [VALUE_W-1:0] v);
    sext_value = {{(SUM_W - VALUE_W){v[VALUE_W-1]}}, v};
  endfunction

endpackage

// ===== hw/rtl/fqsm_div.sv =====
// Serial restoring divider: signed sum by unsigned count, one quotient bit a cycle.
module fqsm_div #(
  parameter int CNT_W = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [fqsm_pkg::SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]                    divisor,
  output logic                                done,
  output logic signed [fqsm_pkg::MEAN_W-1:0]  quotient
);
  import fqsm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic                 run;
  logic [STEP_W-1:0]    step;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dsr;
  logic                 neg;

  logic [CNT_W:0]       rem_sh;
  logic                 fits;
  logic [CNT_W:0]       rem_sub;
  logic [SUM_W-1:0]     quo_signed;

  assign rem_sh     = {rem, quo[SUM_W-1]};
  assign fits       = rem_sh >= {1'b0, dsr};
  assign rem_sub    = rem_sh - {1'b0, dsr};
  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = quo_signed[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        neg  <= dividend[SUM_W-1];
        quo  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (run) begin
        // shift in the next dividend bit, subtract when the divisor fits
        rem  <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo  <= {quo[SUM_W-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/fqsm_front.sv =====
// Front end: accepts items, decodes the action and buffers commands.
module fqsm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [fqsm_pkg::ACTION_W-1:0]        action,
  input  logic signed [fqsm_pkg::VALUE_W-1:0]  value,
  output logic                                 cmd_valid,
  output fqsm_pkg::cmd_t                       cmd,
  input  logic                                 cmd_take
);
  import fqsm_pkg::*;

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] head;
  logic [CMDQ_PTR_W-1:0] tail;
  logic [CMDQ_CNT_W-1:0] fill;
  cmd_t                  decoded;
  logic                  wr;
  logic                  rd;

  always_comb begin
    decoded.value = value;
    case (action)
      ACT_ENQ: decoded.op = OP_ENQ;
      ACT_DEQ: decoded.op = OP_DEQ;
      ACT_CLR: decoded.op = OP_CLR;
      default: decoded.op = OP_NOP;
    endcase
  end

  assign full      = fill == CMDQ_CNT_W'(CMDQ_DEPTH);
  assign cmd_valid = fill != '0;
  assign cmd       = slots[head];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (wr) begin
        slots[tail] <= decoded;
        tail        <= tail + 1'b1;
      end
      if (rd) begin
        head <= head + 1'b1;
      end
      if (wr && !rd) begin
        fill <= fill + 1'b1;
      end else if (rd && !wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/fqsm_back.sv =====
// Back end: ring storage, count and sum update, mean through the divider, result register.
module fqsm_back #(
  parameter int DEPTH = fqsm_pkg::DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cmd_valid,
  input  fqsm_pkg::cmd_t                            cmd,
  output logic                                      cmd_take,
  output logic                                      res_valid,
  input  logic                                      res_pop,
  output fqsm_pkg::status_t                         res_status,
  output logic signed [fqsm_pkg::VALUE_W-1:0]       res_taken,
  output logic [fqsm_pkg::HELD_COUNT_W-1:0]         res_count,
  output logic signed [fqsm_pkg::SUM_W-1:0]         res_sum,
  output logic signed [fqsm_pkg::MEAN_W-1:0]        res_mean
);
  import fqsm_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TAKE,
    S_MEAN,
    S_DIV
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic signed [SUM_W-1:0]    sum;
  logic [PTR_W-1:0]           rd_ptr;
  logic [PTR_W-1:0]           wr_ptr;
  logic [VALUE_W-1:0]         mem [DEPTH];
  logic [VALUE_W-1:0]         rd_data;
  logic                       mem_we;
  logic                       is_full;
  logic                       is_empty;
  logic [PTR_W-1:0]           rd_ptr_next;
  logic [PTR_W-1:0]           wr_ptr_next;
  logic                       div_start;
  logic                       div_done;
  logic signed [MEAN_W-1:0]   div_quot;

  assign is_full     = count == CNT_W'(DEPTH);
  assign is_empty    = count == '0;
  assign cmd_take    = (state == S_IDLE) && cmd_valid && !res_valid;
  assign mem_we      = cmd_take && (cmd.op == OP_ENQ) && !is_full;
  assign rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= cmd.value;
    end
    rd_data <= mem[rd_ptr];
  end

  fqsm_div #(.CNT_W(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sum       <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      res_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            res_status <= ST_DONE;
            res_taken  <= '0;
            state      <= S_MEAN;
            case (cmd.op)
              OP_ENQ: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  wr_ptr <= wr_ptr_next;
                  count  <= count + 1'b1;
                  sum    <= sum + sext_value(cmd.value);
                end
              end
              OP_DEQ: begin
                // go through S_TAKE to use the registered read of the head entry
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_TAKE;
                end
              end
              OP_CLR: begin
                count  <= '0;
                sum    <= '0;
                rd_ptr <= '0;
                wr_ptr <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_TAKE: begin
          res_taken <= rd_data;
          sum       <= sum - sext_value(rd_data);
          count     <= count - 1'b1;
          rd_ptr    <= rd_ptr_next;
          state     <= S_MEAN;
        end
        S_MEAN: begin
          res_count <= HELD_COUNT_W'(count);
          res_sum   <= sum;
          if (is_empty) begin
            res_mean  <= '0;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_mean  <= div_quot;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/fifo_queue_with_sum_and_mean.sv =====
// Top level: bounded FIFO of signed words reporting count, sum and mean per action.
//
//   channel   handshake       payload
//   input     push / full     action, value
//   result    pop / empty     status, taken_value, held_count, held_sum, held_mean
//
// While entries are held, an item's mean comes from the serial divider, which
// produces one quotient bit a cycle. A dequeue passes through the extra S_TAKE
// state for the registered storage read; an item that leaves the queue empty
// skips the divider. A two-entry command buffer keeps push open while the back
// end works or a result waits for pop, until the buffer holds two commands.
// Reset (rst, synchronous) empties the queue and drops buffered commands.
module fifo_queue_with_sum_and_mean #(
  parameter int DEPTH = fqsm_pkg::DEPTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     full,
  input  logic [fqsm_pkg::ACTION_W-1:0]            action,
  input  logic signed [fqsm_pkg::VALUE_W-1:0]      value,
  output logic                                     empty,
  input  logic                                     pop,
  output logic [fqsm_pkg::STATUS_W-1:0]            status,
  output logic signed [fqsm_pkg::VALUE_W-1:0]      taken_value,
  output logic [fqsm_pkg::HELD_COUNT_W-1:0]        held_count,
  output logic signed [fqsm_pkg::SUM_W-1:0]        held_sum,
  output logic signed [fqsm_pkg::MEAN_W-1:0]       held_mean
);
  import fqsm_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_take;
  logic    res_valid;
  status_t res_status;

  fqsm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  fqsm_back #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res_status (res_status),
    .res_taken  (taken_value),
    .res_count  (held_count),
    .res_sum    (held_sum),
    .res_mean   (held_mean)
  );

  assign empty  = !res_valid;
  assign status = res_status;

endmodule

// ===== hw/rtl/fqsm_checker.sv =====
// Port-level checks for the FIFO with running sum and mean, bound to the top level.
module fqsm_checker #(
  parameter int DEPTH = fqsm_pkg::DEPTH_DEF
) (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     empty,
  input logic                                     pop,
  input logic [fqsm_pkg::STATUS_W-1:0]            status,
  input logic signed [fqsm_pkg::VALUE_W-1:0]      taken_value,
  input logic [fqsm_pkg::HELD_COUNT_W-1:0]        held_count,
  input logic signed [fqsm_pkg::SUM_W-1:0]        held_sum,
  input logic signed [fqsm_pkg::MEAN_W-1:0]       held_mean
);
  import fqsm_pkg::*;

  logic refused;
  assign refused = (status == ST_FULL) || (status == ST_EMPTY);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_refused_no_word: assert property (@(posedge clk) disable iff (rst)
    !empty && refused |-> taken_value == '0)
    else $error("refused action reports a taken word");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    !empty && status == ST_FULL |-> held_count == HELD_COUNT_W'(DEPTH))
    else $error("full refusal with count below depth");

  a_drained_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && DEPTH < 256 && held_count == '0 |-> held_sum == '0 && held_mean == '0)
    else $error("empty queue reports nonzero sum or mean");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(held_sum) && $stable(status))
    else $error("waiting result changed before pop");

endmodule

bind fifo_queue_with_sum_and_mean fqsm_checker #(.DEPTH(DEPTH)) u_fqsm_checker (.*);

// ===== sim/fifo_queue_with_sum_and_mean_test.sv =====
// Self-checking testbench for the FIFO with running sum and mean.
`timescale 1ns / 1ps

module fifo_queue_with_sum_and_mean_test;
  import fqsm_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam int IDLE_PCT = 16;
  localparam int RANDOM_ITEMS = 1150;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [ACTION_W-1:0]       act;
    logic signed [VALUE_W-1:0] word;
    bit                        hold;
  } queued_action_t;

  typedef struct {
    status_t                        status;
    logic signed [VALUE_W-1:0]      taken;
    logic [HELD_COUNT_W-1:0]        count;
    logic signed [SUM_W-1:0]        sum;
    logic signed [MEAN_W-1:0]       mean;
  } held_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [ACTION_W-1:0] action = ACT_ENQ;
  logic signed [VALUE_W-1:0] value = '0;
  logic full, empty;
  logic [STATUS_W-1:0] status;
  logic signed [VALUE_W-1:0] taken_value;
  logic [HELD_COUNT_W-1:0] held_count;
  logic signed [SUM_W-1:0] held_sum;
  logic signed [MEAN_W-1:0] held_mean;

  queued_action_t pending_actions[$];
  held_report_t expected_reports[$];

  // predictor state
  logic signed [VALUE_W-1:0] ring [DEPTH];
  int q_rd = 0;
  int q_count = 0;
  logic signed [SUM_W-1:0] q_sum = '0;

  int gen_count = 0;
  int random_items = 0;
  int beats_sent = 0;
  int errors = 0;
  int stall_cycles = 0;
  logic quiet;

  assign quiet = beats_sent >= 500 && beats_sent < 700;

  fifo_queue_with_sum_and_mean uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .action(action), .value(value),
    .empty(empty), .pop(pop),
    .status(status), .taken_value(taken_value), .held_count(held_count),
    .held_sum(held_sum), .held_mean(held_mean)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic held_report_t apply_action(logic [ACTION_W-1:0] act,
                                                logic signed [VALUE_W-1:0] word);
    held_report_t r;
    longint s;
    longint m;
    r.status = ST_DONE;
    r.taken = '0;
    case (act)
      ACT_ENQ: begin
        if (q_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[(q_rd + q_count) % DEPTH] = word;
          q_count++;
          q_sum = q_sum + word;
        end
      end
      ACT_DEQ: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.taken = ring[q_rd];
          q_rd = (q_rd + 1) % DEPTH;
          q_count--;
          q_sum = q_sum - r.taken;
        end
      end
      ACT_CLR: begin
        q_count = 0;
        q_sum = '0;
        q_rd = 0;
      end
      default: ;
    endcase
    s = q_sum;
    m = (q_count == 0) ? 0 : s / q_count;
    r.count = q_count[HELD_COUNT_W-1:0];
    r.sum = q_sum;
    r.mean = m[MEAN_W-1:0];
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic add_action(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] word,
                            bit hold = 1'b0);
    queued_action_t it;
    it.act = act;
    it.word = word;
    it.hold = hold;
    pending_actions.push_back(it);
    case (act)
      ACT_ENQ: if (gen_count < DEPTH) gen_count++;
      ACT_DEQ: if (gen_count > 0) gen_count--;
      ACT_CLR: gen_count = 0;
      default: ;
    endcase
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_word(int mode);
    case (mode)
      1: pick_word = 32'sh7fff_ffff;
      2: pick_word = 32'sh8000_0000;
      3: pick_word = int'($urandom_range(20)) - 10;
      default: pick_word = $urandom;
    endcase
  endfunction

  // input side: predict each accepted beat, then offer the next one
  always @(posedge clk) begin : drive_actions
    queued_action_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_reports.push_back(apply_action(action, value));
        beats_sent++;
      end
      if (!push || !full) begin
        if (pending_actions.size() != 0 &&
            !(pending_actions[0].hold && expected_reports.size() != 0) &&
            (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_actions.pop_front();
          action <= nxt.act;
          value <= nxt.word;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : check_reports
    held_report_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with no expectation waiting");
          errors++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("status", want.status, status);
          compare_field("taken_value", want.taken, taken_value);
          compare_field("held_count", want.count, held_count);
          compare_field("held_sum", want.sum, held_sum);
          compare_field("held_mean", want.mean, held_mean);
        end
      end
      pop <= quiet || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL fifo_queue_with_sum_and_mean");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int mode;
    int n;
    int pick;
    bit first_phase;

    // directed: empty refusal, extremes, spare code, truncation, clear
    add_action(ACT_DEQ, 32'sd5);
    add_action(ACT_SPARE, 32'sh7fff_ffff);
    add_action(ACT_ENQ, 32'sh7fff_ffff);
    add_action(ACT_ENQ, 32'sh7fff_ffff);
    add_action(ACT_ENQ, 32'sd1);
    add_action(ACT_DEQ, 32'sd0);
    add_action(ACT_ENQ, 32'sh8000_0000);
    add_action(ACT_ENQ, 32'sh8000_0000);
    add_action(ACT_SPARE, 32'sh8000_0000);
    add_action(ACT_CLR, 32'sd9);
    add_action(ACT_DEQ, 32'sd0);
    add_action(ACT_ENQ, -32'sd7);
    add_action(ACT_ENQ, 32'sd0);
    add_action(ACT_ENQ, 32'sd5);
    add_action(ACT_ENQ, -32'sd1);
    add_action(ACT_DEQ, 32'sd0);
    add_action(ACT_DEQ, 32'sd0);
    add_action(ACT_DEQ, 32'sd0);
    add_action(ACT_DEQ, 32'sd0);
    add_action(ACT_DEQ, 32'sd0);
    add_action(ACT_ENQ, 32'sd0);
    add_action(ACT_CLR, 32'sh8000_0000);

    first_phase = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      mode = $urandom_range(3);
      if (kind < 25) begin
        // fill past full, with a little noise
        n = DEPTH - gen_count + $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(99);
          if (pick < 5) add_action(ACT_DEQ, $urandom, first_phase && i == 0);
          else if (pick < 9) add_action(ACT_SPARE, $urandom, first_phase && i == 0);
          else add_action(ACT_ENQ, pick_word(mode), first_phase && i == 0);
        end
      end else if (kind < 50) begin
        // drain past empty
        n = gen_count + $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          add_action(ACT_DEQ, $urandom, first_phase && i == 0);
      end else if (kind < 90) begin
        n = $urandom_range(20, 60);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(99);
          if (pick < 45) add_action(ACT_ENQ, pick_word($urandom_range(3)),
                                    first_phase && i == 0);
          else if (pick < 90) add_action(ACT_DEQ, $urandom, first_phase && i == 0);
          else if (pick < 93) add_action(ACT_CLR, $urandom, first_phase && i == 0);
          else add_action(ACT_SPARE, $urandom, first_phase && i == 0);
        end
      end else begin
        n = 1;
        add_action($urandom_range(1) ? ACT_CLR : ACT_SPARE, $urandom,
                   first_phase || $urandom_range(7) == 0);
      end
      random_items += n;
      first_phase = 1'b0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_actions.size() != 0 || push || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS fifo_queue_with_sum_and_mean");
    end else begin
      $display("FAIL fifo_queue_with_sum_and_mean");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fqsm_pkg.sv
hw/rtl/fqsm_div.sv
hw/rtl/fqsm_front.sv
hw/rtl/fqsm_back.sv
hw/rtl/fifo_queue_with_sum_and_mean.sv
hw/rtl/fqsm_checker.sv
sim/fifo_queue_with_sum_and_mean_test.sv
